FILE: sv/fqs_pkg.sv
`timescale 1ns / 1ps
// Package for the feedback queue scheduler: field widths, item and status codes,
// and the command and status groups between controller and datapath. No dependencies.
package fqs_pkg;

  localparam int DEF_SLOTS     = 16;
  localparam int DEF_LEVELS    = 16;
  localparam int DEF_TIME_BITS = 16;

  localparam int SLOT_FW  = 4;
  localparam int SVC_FW   = 16;
  localparam int LEVEL_FW = 4;
  localparam int TIME_FW  = 16;

  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_DROP   = 2'd1,
    ST_RAN    = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic arrive;
    logic dem_rd;
    logic dem_wr;
    logic scan_clr;
    logic scan;
    logic run;
  } fqs_cmd_t;

  typedef struct packed {
    logic pending;
    logic scan_done;
  } fqs_stat_t;

endpackage

FILE: sv/feedback_queue_scheduler.sv
`timescale 1ns / 1ps
// Multilevel feedback scheduler, quantum of one tick. Depends on fqs_pkg, fqs_ctrl, fqs_dp.
// Arrival: done is registered from S_ARR; the next item is accepted back in S_IDLE.
// Tick: S_DEM, then S_DEMW with a pending demotion check, then S_SCAN for the
//   one-slot-per-cycle scan of the slot table, then S_RUN, from which done is registered.
// done is a single-cycle strobe, results hold, the receiver cannot stall. Synchronous
//   reset frees all slots and clears time; the slot table needs no clearing pass.
module feedback_queue_scheduler
  import fqs_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int LEVELS    = DEF_LEVELS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                kind,
  input  logic [SLOT_FW-1:0]  slot,
  input  logic [SVC_FW-1:0]   service_time,
  output logic                done,
  output logic [1:0]          status,
  output logic [SLOT_FW-1:0]  run_slot,
  output logic [LEVEL_FW-1:0] run_level,
  output logic                finished,
  output logic [TIME_FW-1:0]  finish_time,
  output logic [TIME_FW-1:0]  turnaround
);

  fqs_cmd_t  cmd;
  fqs_stat_t st;

  fqs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  fqs_dp #(
    .SLOTS     (SLOTS),
    .LEVELS    (LEVELS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .slot         (slot),
    .service_time (service_time),
    .done         (done),
    .status       (status),
    .run_slot     (run_slot),
    .run_level    (run_level),
    .finished     (finished),
    .finish_time  (finish_time),
    .turnaround   (turnaround)
  );

endmodule

FILE: sv/fqs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fqs_ctrl.sv
`timescale 1ns / 1ps
// Controller of the feedback queue scheduler: sequences arrival and tick items.
// Depends on fqs_pkg.
module fqs_ctrl
  import fqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      kind,
  input  fqs_stat_t st,
  output fqs_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR,
    S_DEM,
    S_DEMW,
    S_SCAN,
    S_RUN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= (kind == KIND_ARRIVAL) ? S_ARR : S_DEM;
          end
        end
        S_ARR: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        S_DEM: begin
          state <= st.pending ? S_DEMW : S_SCAN;
        end
        S_DEMW: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (st.scan_done) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.arrive   = (state == S_ARR);
    cmd.scan_clr = (state == S_DEM);
    cmd.dem_rd   = (state == S_DEM) && st.pending;
    cmd.dem_wr   = (state == S_DEMW);
    cmd.scan     = (state == S_SCAN);
    cmd.run      = (state == S_RUN);
  end

endmodule

FILE: sv/fqs_dp.sv
`timescale 1ns / 1ps
// Datapath of the feedback queue scheduler: slot table, busy bits, time,
// minimum-level scan and result registers. Depends on fqs_pkg and fqs_ram.
module fqs_dp
  import fqs_pkg::*;
#(
  parameter int SLOTS     = DEF_SLOTS,
  parameter int LEVELS    = DEF_LEVELS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  fqs_cmd_t            cmd,
  output fqs_stat_t           st,
  input  logic [SLOT_FW-1:0]  slot,
  input  logic [SVC_FW-1:0]   service_time,
  output logic                done,
  output logic [1:0]          status,
  output logic [SLOT_FW-1:0]  run_slot,
  output logic [LEVEL_FW-1:0] run_level,
  output logic                finished,
  output logic [TIME_FW-1:0]  finish_time,
  output logic [TIME_FW-1:0]  turnaround
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int LEVEL_W = $clog2(LEVELS);
  localparam int WORD_W  = LEVEL_W + SVC_FW + TIME_BITS;

  logic [SLOT_FW-1:0]   in_slot;
  logic [SVC_FW-1:0]    in_svc;
  logic [SLOTS-1:0]     busy_bits;
  logic [TIME_BITS-1:0] now;
  logic [SLOT_W-1:0]    last_run;
  logic                 pending;
  logic [CNT_W-1:0]     cnt;
  logic                 cmp_valid;
  logic [SLOT_W-1:0]    cmp_idx;
  logic                 found;
  logic [SLOT_W-1:0]    sel;
  logic [LEVEL_W-1:0]   best_lvl;
  logic [SVC_FW-1:0]    best_rem;
  logic [TIME_BITS-1:0] best_stamp;

  logic                 we;
  logic [SLOT_W-1:0]    waddr;
  logic [WORD_W-1:0]    wdata;
  logic [SLOT_W-1:0]    raddr;
  logic [WORD_W-1:0]    rdata;

  logic [LEVEL_W-1:0]   rd_lvl;
  logic [SVC_FW-1:0]    rd_rem;
  logic [TIME_BITS-1:0] rd_stamp;
  logic [SLOT_W-1:0]    in_idx;
  logic                 drop;
  logic                 other;
  logic                 take;
  logic                 fin;
  logic [TIME_BITS-1:0] done_time;
  logic [TIME_BITS-1:0] turn_time;

  fqs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_lvl    = rdata[WORD_W-1 -: LEVEL_W];
  assign rd_rem    = rdata[TIME_BITS +: SVC_FW];
  assign rd_stamp  = rdata[TIME_BITS-1:0];
  assign in_idx    = SLOT_W'(in_slot);
  assign drop      = (32'(in_slot) >= SLOTS) || busy_bits[in_idx];
  assign other     = |(busy_bits & ~(SLOTS'(1) << last_run));
  assign take      = cmp_valid && busy_bits[cmp_idx] && (!found || (rd_lvl < best_lvl));
  assign fin       = best_rem <= SVC_FW'(1);
  assign done_time = now + 1'b1;
  assign turn_time = done_time - best_stamp;

  assign st.pending   = pending;
  assign st.scan_done = (cnt == CNT_W'(SLOTS)) && !cmp_valid;

  assign raddr = cmd.dem_rd ? last_run : cnt[SLOT_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = in_idx;
    wdata = {LEVEL_W'(0), in_svc, now};
    if (cmd.arrive) begin
      we = !drop;
    end else if (cmd.dem_wr) begin
      we    = other && (rd_lvl < LEVEL_W'(LEVELS - 1));
      waddr = last_run;
      wdata = {rd_lvl + 1'b1, rd_rem, rd_stamp};
    end else if (cmd.run) begin
      we    = found && !fin;
      waddr = sel;
      wdata = {best_lvl, best_rem - 1'b1, best_stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_slot <= slot;
      in_svc  <= service_time;
    end
    if (cmd.scan) begin
      cmp_idx <= cnt[SLOT_W-1:0];
    end
    if (cmd.scan && take) begin
      sel        <= cmp_idx;
      best_lvl   <= rd_lvl;
      best_rem   <= rd_rem;
      best_stamp <= rd_stamp;
    end
    if (cmd.arrive) begin
      status      <= drop ? ST_DROP : ST_ACCEPT;
      run_slot    <= '0;
      run_level   <= '0;
      finished    <= 1'b0;
      finish_time <= '0;
      turnaround  <= '0;
    end else if (cmd.run) begin
      status      <= found ? ST_RAN : ST_IDLE;
      run_slot    <= found ? SLOT_FW'(sel) : '0;
      run_level   <= found ? LEVEL_FW'(best_lvl) : '0;
      finished    <= found && fin;
      finish_time <= (found && fin) ? TIME_FW'(done_time) : '0;
      turnaround  <= (found && fin) ? TIME_FW'(turn_time) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_bits <= '0;
      now       <= '0;
      last_run  <= '0;
      pending   <= 1'b0;
      cnt       <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= cmd.arrive || cmd.run;
      if (cmd.arrive && !drop) begin
        busy_bits[in_idx] <= 1'b1;
      end
      if (cmd.dem_rd) begin
        pending <= 1'b0;
      end
      if (cmd.scan_clr) begin
        cnt       <= '0;
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan) begin
        if (cnt != CNT_W'(SLOTS)) begin
          cnt       <= cnt + 1'b1;
          cmp_valid <= 1'b1;
        end else begin
          cmp_valid <= 1'b0;
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if (cmd.run) begin
        now <= done_time;
        if (found && fin) begin
          busy_bits[sel] <= 1'b0;
        end else if (found) begin
          last_run <= sel;
          pending  <= 1'b1;
        end
      end
    end
  end

  a_arrive_marks_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.arrive && !drop |=> busy_bits[$past(in_idx)])
    else $error("accepted arrival did not mark its slot busy");

  a_finish_frees_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.run && found && fin |=> !busy_bits[$past(sel)])
    else $error("finished job still holds its slot");

  a_pending_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(pending) |-> $past(cmd.run) && $past(found))
    else $error("demotion armed without an unfinished run");

  a_tick_advances_time: assert property (@(posedge clk) disable iff (rst)
    cmd.run |=> now == $past(now) + 1'b1)
    else $error("tick did not advance time by one");

endmodule
